/* sv/gcl_pkg.sv */
// gcl_pkg: request/result types, microcode encoding and control ROM for gcd_lcm_unit.
// Depends on nothing; used by gcl_useq, gcl_datapath and gcd_lcm_unit.
package gcl_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned LCM_W    = 64;
  localparam int unsigned UPC_W    = 4;

  typedef struct packed {
    logic [FIELD_W-1:0] first_operand;
    logic [FIELD_W-1:0] second_operand;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] gcd_value;
    logic [LCM_W-1:0]   lcm_value;
    logic               error_flag;
  } out_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_HALVE_BOTH,
    OP_HALVE_X,
    OP_HALVE_Y,
    OP_SUB,
    OP_GSHIFT,
    OP_DIVSTEP,
    OP_MUL,
    OP_FINISH,
    OP_FAIL
  } op_t;

  // Jump conditions; a true condition runs the op and takes the jump.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ANY_ZERO,
    C_BOTH_EVEN,
    C_X_EVEN,
    C_Y_EVEN,
    C_X_NE_Y,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic load;
    logic step;
    op_t  op;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic any_zero;
    logic both_even;
    logic x_even;
    logic y_even;
    logic x_ne_y;
    logic div_more;
  } status_t;

  localparam logic [UPC_W-1:0] UA_CHECK    = 4'd0;
  localparam logic [UPC_W-1:0] UA_PAIR     = 4'd1;
  localparam logic [UPC_W-1:0] UA_XEVEN    = 4'd2;
  localparam logic [UPC_W-1:0] UA_YEVEN    = 4'd3;
  localparam logic [UPC_W-1:0] UA_SUB      = 4'd4;
  localparam logic [UPC_W-1:0] UA_GSHIFT   = 4'd5;
  localparam logic [UPC_W-1:0] UA_DIVLOOP  = 4'd6;
  localparam logic [UPC_W-1:0] UA_DIVLAST  = 4'd7;
  localparam logic [UPC_W-1:0] UA_MUL      = 4'd8;
  localparam logic [UPC_W-1:0] UA_FINISH   = 4'd9;
  localparam logic [UPC_W-1:0] UA_FAIL     = 4'd10;

  // Control program: binary GCD, restoring divide of the first operand by
  // the GCD, then one multiply by the second operand.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    begin
      unique case (addr)
        UA_CHECK:   w = '{op: OP_NONE,       cond: C_ANY_ZERO,  target: UA_FAIL};
        UA_PAIR:    w = '{op: OP_HALVE_BOTH, cond: C_BOTH_EVEN, target: UA_PAIR};
        UA_XEVEN:   w = '{op: OP_HALVE_X,    cond: C_X_EVEN,    target: UA_XEVEN};
        UA_YEVEN:   w = '{op: OP_HALVE_Y,    cond: C_Y_EVEN,    target: UA_YEVEN};
        UA_SUB:     w = '{op: OP_SUB,        cond: C_X_NE_Y,    target: UA_XEVEN};
        UA_GSHIFT:  w = '{op: OP_GSHIFT,     cond: C_ALWAYS,    target: UA_DIVLOOP};
        UA_DIVLOOP: w = '{op: OP_DIVSTEP,    cond: C_DIV_MORE,  target: UA_DIVLOOP};
        UA_DIVLAST: w = '{op: OP_DIVSTEP,    cond: C_ALWAYS,    target: UA_MUL};
        UA_MUL:     w = '{op: OP_MUL,        cond: C_ALWAYS,    target: UA_FINISH};
        UA_FINISH:  w = '{op: OP_FINISH,     cond: C_ALWAYS,    target: UA_CHECK};
        UA_FAIL:    w = '{op: OP_FAIL,       cond: C_ALWAYS,    target: UA_CHECK};
        default:    w = '{op: OP_FAIL,       cond: C_ALWAYS,    target: UA_CHECK};
      endcase
      return w;
    end
  endfunction

endpackage

/* sv/gcl_useq.sv */
// gcl_useq: microcode sequencer (step counter, control ROM fetch, jump test).
// Depends on gcl_pkg.
module gcl_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  gcl_pkg::status_t  status,
  output gcl_pkg::ctrl_t    ctrl,
  output logic              busy
);
  import gcl_pkg::*;

  logic [UPC_W-1:0] pc;
  logic [UPC_W-1:0] pc_next;
  uword_t           uw;
  logic             cond_true;

  always_comb begin
    uw = ucode_rom(pc);
    unique case (uw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_ANY_ZERO:  cond_true = status.any_zero;
      C_BOTH_EVEN: cond_true = status.both_even;
      C_X_EVEN:    cond_true = status.x_even;
      C_Y_EVEN:    cond_true = status.y_even;
      C_X_NE_Y:    cond_true = status.x_ne_y;
      C_DIV_MORE:  cond_true = status.div_more;
      default:     cond_true = 1'b1;
    endcase
    pc_next   = cond_true ? uw.target : pc + UPC_W'(1);
    ctrl.load = start && !busy;
    ctrl.step = busy && cond_true;
    ctrl.op   = uw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= UA_CHECK;
    end else if (ctrl.load) begin
      busy <= 1'b1;
      pc   <= UA_CHECK;
    end else if (busy) begin
      pc <= pc_next;
      // drop busy when the program emits its result
      if (ctrl.step && (uw.op == OP_FINISH || uw.op == OP_FAIL)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* sv/gcl_datapath.sv */
// gcl_datapath: operand registers, subtract/shift unit, restoring divider step,
// multiplier and result register. Depends on gcl_pkg.
module gcl_datapath #(
  parameter int unsigned W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  gcl_pkg::in_t     request,
  input  gcl_pkg::ctrl_t   ctrl,
  output gcl_pkg::status_t status,
  output gcl_pkg::out_t    result,
  output logic             done
);
  import gcl_pkg::*;

  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     x;
  logic [W-1:0]     y;
  logic [W-1:0]     a_orig;
  logic [W-1:0]     b_orig;
  logic [CNT_W-1:0] k;
  logic [W-1:0]     g;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [CNT_W-1:0] cnt;
  logic [2*W-1:0]   prod;
  logic [W:0]       shifted;
  logic [W:0]       trial;

  always_comb begin
    status.any_zero  = (x == '0) || (y == '0);
    status.both_even = !x[0] && !y[0];
    status.x_even    = !x[0];
    status.y_even    = !y[0];
    status.x_ne_y    = (x != y);
    status.div_more  = (cnt != CNT_W'(W - 1));
    shifted          = {rem, quo[W-1]};
    trial            = shifted - {1'b0, g};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.step && (ctrl.op == OP_FINISH || ctrl.op == OP_FAIL);
    end

    if (ctrl.load) begin
      x      <= request.first_operand[W-1:0];
      y      <= request.second_operand[W-1:0];
      a_orig <= request.first_operand[W-1:0];
      b_orig <= request.second_operand[W-1:0];
      k      <= '0;
    end else if (ctrl.step) begin
      case (ctrl.op)
        OP_HALVE_BOTH: begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + CNT_W'(1);
        end
        OP_HALVE_X: x <= x >> 1;
        OP_HALVE_Y: y <= y >> 1;
        OP_SUB: begin
          if (x < y) begin
            y <= y - x;
          end else begin
            x <= x - y;
          end
        end
        OP_GSHIFT: begin
          g   <= x << k;
          rem <= '0;
          quo <= a_orig;
          cnt <= '0;
        end
        OP_DIVSTEP: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= shifted[W-1:0];
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
        end
        OP_MUL: prod <= (2*W)'(quo) * (2*W)'(b_orig);
        OP_FINISH: begin
          result.gcd_value  <= FIELD_W'(g);
          result.lcm_value  <= LCM_W'(prod);
          result.error_flag <= 1'b0;
        end
        OP_FAIL: begin
          result.gcd_value  <= '0;
          result.lcm_value  <= '0;
          result.error_flag <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/gcd_lcm_unit.sv */
// gcd_lcm_unit: GCD and LCM of two unsigned operands, microcoded sequencer top level.
// Depends on gcl_pkg, gcl_useq and gcl_datapath.
// The divide loop (one quotient bit a cycle) and the subtract/shift GCD loop of the single
//   datapath set the run time; a zero operand goes straight to the error result.
// Throughput: one request at a time; busy drops with the done strobe, so the next request
//   may start in that very cycle. Results cannot be stalled.
// Reset (rst, synchronous): clears busy, the step counter and done; data registers hold.
module gcd_lcm_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gcl_pkg::in_t  request,
  output logic          busy,
  output logic          done,
  output gcl_pkg::out_t result
);
  import gcl_pkg::*;

  // Control words from the sequencer, condition flags back from the datapath.
  ctrl_t   ctrl;
  status_t status;

  // Sequencer: step counter and control ROM. A request is taken when start is
  // high while busy is low; the program then runs until it emits a result.
  gcl_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Datapath: only the low OPERAND_WIDTH bits of each operand are used. The
  // GCD comes from the binary method (common power of two kept in a shift
  // count), the LCM from (first / gcd) * second at double width.
  gcl_datapath #(
    .W (OPERAND_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctrl    (ctrl),
    .status  (status),
    .result  (result),
    .done    (done)
  );

  // The done strobe comes with the step that also clears busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while the sequencer is still busy");

  // An accepted request always puts the sequencer to work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not set");

  // Error results carry zero values, good results a nonzero GCD and LCM.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.error_flag) |-> (result.gcd_value == '0 && result.lcm_value == '0))
    else $error("error result with nonzero value");

  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.error_flag) |-> (result.gcd_value != '0 && result.lcm_value != '0))
    else $error("good result with zero GCD or LCM");

endmodule
